// ----- design/tes_pkg.sv -----
// tes_pkg: types, effect codes and constants of the tone effect sequencer
// no dependencies; used by the interfaces, the divider, the top level and the checker
package tes_pkg;

    // payload widths
    localparam int EFFECT_W  = 3;
    localparam int TOP_W     = 13;
    localparam int CMP_W     = 8;
    localparam int FREQ_W    = 10;
    localparam int DUTY_W    = 3;

    // event modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // effect codes
    localparam logic [EFFECT_W-1:0] EFF_SILENT      = 3'd0;
    localparam logic [EFFECT_W-1:0] EFF_SWEEP_LOW   = 3'd1;
    localparam logic [EFFECT_W-1:0] EFF_SWEEP_HIGH  = 3'd2;
    localparam logic [EFFECT_W-1:0] EFF_STEPS_SHORT = 3'd3;
    localparam logic [EFFECT_W-1:0] EFF_STEPS_LONG  = 3'd4;

    // timer clock and divider geometry
    localparam int                 DIVIDEND_W = 20;
    localparam logic [DIVIDEND_W-1:0] TIMER_HZ = 20'd1000000;
    localparam int                 DIV_CNT_W  = 5;

    // divide by 100 as multiply by ceil(2^19/100) and shift
    localparam int            PROD_W       = 15;
    localparam int            RECIP_SHIFT  = 19;
    localparam int            SCALE_W      = 28;
    localparam logic [12:0]   RECIP_100    = 13'd5243;

    // frequencies in Hz
    localparam logic [FREQ_W-1:0] FREQ_FLOOR = 10'd200;
    localparam logic [FREQ_W-1:0] FREQ_300   = 10'd300;
    localparam logic [FREQ_W-1:0] FREQ_400   = 10'd400;
    localparam logic [FREQ_W-1:0] FREQ_450   = 10'd450;
    localparam logic [FREQ_W-1:0] FREQ_650   = 10'd650;
    localparam logic [FREQ_W-1:0] FREQ_700   = 10'd700;
    localparam logic [FREQ_W-1:0] FREQ_750   = 10'd750;

    // tick limits
    localparam int SWEEP_END       = 11;
    localparam int SWEEP_LOW_SAT   = 15;  // 300 - 7*t drops below the floor
    localparam int SWEEP_HIGH_SAT  = 65;  // 650 - 7*t drops below the floor
    localparam int STEP_T1         = 10;
    localparam int STEP_T2         = 20;
    localparam int STEP_T3         = 30;
    localparam int STEP_T4         = 40;
    localparam int STEP_T5         = 50;
    localparam int STEPS_SHORT_END = 40;
    localparam int STEPS_LONG_END  = 60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_SCALE,
        ST_FINISH
    } tes_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tes_div_status_t;

    function automatic logic [DUTY_W-1:0] duty_of(input logic [EFFECT_W-1:0] id);
        logic [DUTY_W-1:0] d;
        begin
            case (id)
                EFF_SWEEP_LOW:   d = 3'd2;
                EFF_SWEEP_HIGH:  d = 3'd1;
                EFF_STEPS_SHORT: d = 3'd4;
                EFF_STEPS_LONG:  d = 3'd5;
                default:         d = 3'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// ----- design/tes_in_if.sv -----
// tes_in_if: event channel of the tone effect sequencer, valid/ready with payload
// depends on tes_pkg
interface tes_in_if import tes_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                mode;
    logic [EFFECT_W-1:0] effect_id;
    logic                mute;

    modport source (output valid, mode, effect_id, mute, input ready);
    modport sink   (input valid, mode, effect_id, mute, output ready);
endinterface

// ----- design/tes_out_if.sv -----
// tes_out_if: result channel of the tone effect sequencer, valid/ready with payload
// depends on tes_pkg
interface tes_out_if import tes_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOP_W-1:0] period_top;
    logic [CMP_W-1:0] pulse_compare;
    logic             written;
    logic             playing;

    modport source (output valid, period_top, pulse_compare, written, playing, input ready);
    modport sink   (input valid, period_top, pulse_compare, written, playing, output ready);
endinterface

// ----- design/tes_div.sv -----
// tes_div: bit-serial restoring divider, timer clock over frequency, one quotient bit a cycle
// depends on tes_pkg
module tes_div import tes_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [FREQ_W-1:0]   divisor,
    output tes_div_status_t     status,
    output logic [TOP_W-1:0]    quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FREQ_W-1:0]    rem_reg, rem_next;
    logic [TOP_W-1:0]     quo_reg, quo_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] bit_idx;
    logic [FREQ_W:0]      rem_shift;
    logic [FREQ_W:0]      dsor_ext;
    logic                 ge;

    assign bit_idx   = DIV_CNT_W'(DIVIDEND_W - 1) - cnt_reg;
    assign rem_shift = {rem_reg, TIMER_HZ[bit_idx]};
    assign dsor_ext  = {1'b0, divisor};
    assign ge        = rem_shift >= dsor_ext;

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient never exceeds 13 bits, upper bits shift out as zeros
            rem_next = ge ? FREQ_W'(rem_shift - dsor_ext) : rem_shift[FREQ_W-1:0];
            quo_next = {quo_reg[TOP_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ----- design/tone_effect_sequencer.sv -----
// tone_effect_sequencer: top level, effect state, sequencing and PWM value arithmetic
// depends on tes_pkg, tes_in_if, tes_out_if and tes_div
//
// usage: events carries one item per start or tick event (mode, effect_id, mute);
// pwm returns exactly one item per event with the PWM top and compare values,
// a flag that they were written, and whether an effect is still playing.
// an event that writes real PWM values divides the 1 MHz timer clock by the
// frequency in a bit-serial divider, one quotient bit per cycle in 20 steps,
// followed by one multiply and one scale step, then the final step loads the
// output register. events that write nothing, or write zeros on a stop or at
// an effect's end, skip the divider and go from accept straight to the final
// step. the 20-step divider sets the rate. one item is in work at a time;
// events.ready is high only while no item is in work.
// the result sits in an output register, so the next item is taken while an
// earlier result still waits; if pwm stalls, the following result waits in
// the final step until the register frees up.
// reset: silent, tick count zero, held frequency 200 Hz, duty 2 percent, no
// result pending.
module tone_effect_sequencer import tes_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tes_in_if.sink     events,
    tes_out_if.source  pwm
);

    localparam int TW = TICK_COUNT_WIDTH;

    tes_state_t            state_reg, state_next;
    logic [EFFECT_W-1:0]   active_reg, active_next;
    logic [TW-1:0]         tick_reg, tick_next;
    logic [FREQ_W-1:0]     held_reg, held_next;
    logic [DUTY_W-1:0]     duty_reg, duty_next;
    logic                  written_reg, written_next;
    logic [TOP_W-1:0]      top_reg, top_next;
    logic [CMP_W-1:0]      cmp_reg, cmp_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;

    logic                  out_valid_reg, out_valid_next;
    logic [TOP_W-1:0]      out_top_reg, out_top_next;
    logic [CMP_W-1:0]      out_cmp_reg, out_cmp_next;
    logic                  out_written_reg, out_written_next;
    logic                  out_playing_reg, out_playing_next;

    logic                  accept;
    logic                  is_start;
    logic                  is_stop;
    logic [EFFECT_W-1:0]   eff;
    logic [TW-1:0]         t;
    logic [6:0]            t7;
    logic [FREQ_W-1:0]     sweep_base;
    logic [FREQ_W-1:0]     sweep_freq;
    logic                  sweep_sat;
    logic                  need_div;
    logic                  div_start;
    tes_div_status_t       div_status;
    logic [TOP_W-1:0]      quotient;
    logic [SCALE_W-1:0]    scaled;
    logic [CMP_W-1:0]      width;

    tes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (held_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    assign events.ready = (state_reg == ST_IDLE);
    assign accept       = events.valid && events.ready;
    assign div_start    = (state_reg == ST_START);

    // event decode and the tick the effect logic sees
    assign is_start = (events.mode == MODE_START);
    assign is_stop  = is_start && !(events.effect_id inside {[EFF_SWEEP_LOW:EFF_STEPS_LONG]});
    assign eff      = is_start ? events.effect_id : active_reg;
    assign t        = (is_start ? TW'(1) : tick_reg) + 1'b1;
    assign t7       = t[6:0];

    // sweep: base - 7*t, floored at 200 once t reaches the saturation point
    assign sweep_base = (eff == EFF_SWEEP_LOW) ? FREQ_300 : FREQ_650;
    assign sweep_sat  = (eff == EFF_SWEEP_LOW) ? (t >= TW'(SWEEP_LOW_SAT))
                                               : (t >= TW'(SWEEP_HIGH_SAT));
    assign sweep_freq = sweep_sat ? FREQ_FLOOR
                                  : FREQ_W'(sweep_base - (FREQ_W'({t7, 3'b000}) - FREQ_W'(t7)));

    assign scaled = SCALE_W'(prod_reg) * SCALE_W'(RECIP_100);
    assign width  = scaled[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        tick_next    = tick_reg;
        held_next    = held_reg;
        duty_next    = duty_reg;
        written_next = written_reg;
        top_next     = top_reg;
        cmp_next     = cmp_reg;
        prod_next    = prod_reg;
        need_div     = 1'b0;

        out_valid_next   = out_valid_reg && !pwm.ready;
        out_top_next     = out_top_reg;
        out_cmp_next     = out_cmp_reg;
        out_written_next = out_written_reg;
        out_playing_next = out_playing_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    written_next = 1'b0;
                    top_next     = '0;
                    cmp_next     = '0;
                    if (is_stop)
                    begin
                        active_next  = EFF_SILENT;
                        tick_next    = '0;
                        written_next = 1'b1;
                    end
                    else
                    begin
                        if (is_start)
                        begin
                            active_next = eff;
                            duty_next   = duty_of(eff);
                        end
                        tick_next = t;
                        if (!events.mute && eff != EFF_SILENT)
                        begin
                            written_next = 1'b1;
                            need_div     = 1'b1;
                            case (eff)
                                EFF_SWEEP_LOW, EFF_SWEEP_HIGH:
                                begin
                                    held_next = sweep_freq;
                                    if (t >= TW'(SWEEP_END))
                                    begin
                                        active_next = EFF_SILENT;
                                        tick_next   = '0;
                                        need_div    = 1'b0;
                                    end
                                end
                                EFF_STEPS_SHORT:
                                begin
                                    if (t < TW'(STEP_T1))
                                        held_next = FREQ_300;
                                    else if (t < TW'(STEP_T2))
                                        held_next = FREQ_450;
                                    else if (t < TW'(STEP_T3))
                                        held_next = FREQ_650;
                                    else if (t > TW'(STEPS_SHORT_END))
                                    begin
                                        active_next = EFF_SILENT;
                                        tick_next   = '0;
                                        need_div    = 1'b0;
                                    end
                                end
                                default:
                                begin
                                    if (t < TW'(STEP_T1))
                                        held_next = FREQ_400;
                                    else if (t < TW'(STEP_T2))
                                        held_next = FREQ_450;
                                    else if (t < TW'(STEP_T3))
                                        held_next = FREQ_650;
                                    else if (t < TW'(STEP_T4))
                                        held_next = FREQ_700;
                                    else if (t < TW'(STEP_T5))
                                        held_next = FREQ_750;
                                    else if (t > TW'(STEPS_LONG_END))
                                    begin
                                        active_next = EFF_SILENT;
                                        tick_next   = '0;
                                        need_div    = 1'b0;
                                    end
                                end
                            endcase
                        end
                    end
                    state_next = need_div ? ST_START : ST_FINISH;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                top_next   = quotient - 1'b1;
                prod_next  = PROD_W'(duty_reg) * PROD_W'(quotient);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmp_next   = (width == '0) ? '0 : width - 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || pwm.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_top_next     = top_reg;
                    out_cmp_next     = cmp_reg;
                    out_written_next = written_reg;
                    out_playing_next = (active_reg != EFF_SILENT);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= EFF_SILENT;
            tick_reg      <= '0;
            held_reg      <= FREQ_FLOOR;
            duty_reg      <= duty_of(EFF_SWEEP_LOW);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            tick_reg      <= tick_next;
            held_reg      <= held_next;
            duty_reg      <= duty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        written_reg     <= written_next;
        top_reg         <= top_next;
        cmp_reg         <= cmp_next;
        prod_reg        <= prod_next;
        out_top_reg     <= out_top_next;
        out_cmp_reg     <= out_cmp_next;
        out_written_reg <= out_written_next;
        out_playing_reg <= out_playing_next;
    end

    assign pwm.valid         = out_valid_reg;
    assign pwm.period_top    = out_top_reg;
    assign pwm.pulse_compare = out_cmp_reg;
    assign pwm.written       = out_written_reg;
    assign pwm.playing       = out_playing_reg;

endmodule

// ----- design/tes_checker.sv -----
// tes_checker: port-level assertions for the tone effect sequencer, bound to the top level
// depends on tes_pkg and tone_effect_sequencer
module tes_checker import tes_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             ev_valid,
    input logic             ev_ready,
    input logic             pwm_valid,
    input logic             pwm_ready,
    input logic [TOP_W-1:0] period_top,
    input logic [CMP_W-1:0] pulse_compare,
    input logic             written,
    input logic             playing
);

    // an item that writes nothing carries zero PWM values
    a_zero_unwritten: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_valid && !written |-> period_top == '0 && pulse_compare == '0)
        else $error("unwritten item carries nonzero pwm values");

    // a written nonzero period goes with a playing effect, zeros with silence
    a_top_playing: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_valid && written |-> (period_top != '0) == playing)
        else $error("period_top does not agree with playing");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_valid |-> period_top <= TOP_W'(4999))
        else $error("period_top out of range");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_ready |=> !ev_ready)
        else $error("event accepted while another is in work");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_valid && !pwm_ready |=> pwm_valid && $stable(period_top)
            && $stable(pulse_compare) && $stable(written) && $stable(playing))
        else $error("stalled result changed");

endmodule

bind tone_effect_sequencer tes_checker u_tes_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_valid      (events.valid),
    .ev_ready      (events.ready),
    .pwm_valid     (pwm.valid),
    .pwm_ready     (pwm.ready),
    .period_top    (pwm.period_top),
    .pulse_compare (pwm.pulse_compare),
    .written       (pwm.written),
    .playing       (pwm.playing)
);
